// ===== sv/csa_pkg.sv =====
`default_nettype none
package csa_pkg;

  localparam int SEG_N   = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int BASE_W  = 20;
  localparam int LEN_W   = 21;
  localparam int SIZE_W  = 21;
  localparam logic [LEN_W-1:0] MEM_BYTES = 21'd1048576;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_STATUS  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NONE  = 2'd3
  } fit_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic              used;
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } seg_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_SHIFT = 2'd1,
    OP_SQZ   = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     parity;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/csa_cell.sv =====
`default_nettype none
module csa_cell
  import csa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head,
  input  wire logic      odd,
  input  wire cell_ctl_t ctl,
  input  wire seg_t      left_in,
  input  wire seg_t      right_in,
  output seg_t           ent
);

  logic is_left;

  assign is_left = (odd == ctl.parity);

  always_ff @(posedge clk) begin
    if (rst) begin
      if (head) ent <= '{valid: 1'b1, used: 1'b0, base: '0, len: MEM_BYTES};
      else ent <= '0;
    end else begin
      unique case (ctl.op)
        OP_SHIFT: ent <= right_in;
        OP_SQZ: begin
          if (is_left) begin
            if (!ent.valid && right_in.valid) ent <= right_in;
          end else begin
            if (!left_in.valid && ent.valid) ent.valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/contiguous_segment_allocator_unit.sv =====
// Flow: a scan pass around the cell chain, a rewrite pass, an odd-even squeeze of the
// chain, then the result is loaded into the output register in S_FIN.
// A new transaction is taken only in S_IDLE; the cell chain serves one command at a time.
// A finished result waits in the output register while the next input is taken.
// Reset (rst, synchronous): the table holds one hole covering all memory.
`default_nettype none
module contiguous_segment_allocator_unit
  import csa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // fit_mode, alloc_size, release_start, zero pad
  input  wire logic [1:0]  s_tuser,  // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata   // status_code, granted_start, bytes_used,
                                     // used_segments, hole_segments, zero pad
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_REWR = 5'b00100,
    S_SQZ  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cyc;
  logic [IDX_W-1:0] idx;

  cmd_t              cmd_r;
  fit_t              mode_r;
  logic [SIZE_W-1:0] size_r;
  logic [BASE_W-1:0] start_r;

  logic [CNT_W-1:0]  tot;
  logic              found;
  logic [IDX_W-1:0]  pick;
  logic [LEN_W-1:0]  pick_len;
  logic [BASE_W-1:0] pick_base;
  logic              rfound;
  logic [IDX_W-1:0]  ridx;
  logic              rused;

  seg_t              q0, q1;
  logic [1:0]        qn;
  logic [LEN_W-1:0]  nb, free_b;
  logic [LEN_W-1:0]  bytes;
  logic [CNT_W-1:0]  ucnt, hcnt;

  seg_t              ents [SEG_N];
  seg_t              tail_in;
  seg_t              left_wall;
  cell_ctl_t         ctl;

  assign idx = cyc[IDX_W-1:0];
  assign s_tready = (state == S_IDLE);

  // command outcome
  logic    size0, mode_bad, split_need, full, alloc_ok, rel_ok, cmp_mode;
  status_t alloc_st;

  assign size0      = (size_r == '0);
  assign mode_bad   = (mode_r != FIT_FIRST) && (mode_r != FIT_BEST) && (mode_r != FIT_WORST);
  assign split_need = (pick_len > size_r);
  assign full       = (tot >= CNT_W'(SEG_N));
  assign alloc_ok   = (cmd_r == CMD_ALLOC) && !size0 && !mode_bad && found &&
                      !(split_need && full);
  assign rel_ok     = (cmd_r == CMD_RELEASE) && rfound && rused;
  assign cmp_mode   = (cmd_r == CMD_COMPACT);

  always_comb begin
    if (size0) alloc_st = ST_FULL;
    else if (mode_bad || !found) alloc_st = ST_NO_FIT;
    else if (split_need && full) alloc_st = ST_FULL;
    else alloc_st = ST_OK;
  end

  // scan candidate
  seg_t sx;
  logic cand, take;
  assign sx   = ents[0];
  assign cand = sx.valid && !sx.used && (sx.len >= size_r);
  always_comb begin
    take = 1'b0;
    if (cand) begin
      if (!found) take = 1'b1;
      else if (mode_r == FIT_BEST && sx.len < pick_len) take = 1'b1;
      else if (mode_r == FIT_WORST && sx.len > pick_len) take = 1'b1;
    end
  end

  // rewrite stream
  seg_t             x, xm, n0, n1, qm0, qm1, hole, emit;
  seg_t             c [4];
  logic [2:0]       nn, cn;
  logic             pop;
  logic [LEN_W-1:0] free_nx, nb_nx;

  always_comb begin
    x  = cyc[IDX_W] ? '0 : ents[0];
    xm = x;
    if (rel_ok && idx == ridx) xm.used = 1'b0;
    n0 = '0;
    n1 = '0;
    nn = 3'd0;
    qm0 = q0;
    qm1 = q1;
    free_nx = free_b;
    nb_nx = nb;
    hole = '0;
    if (cmp_mode) begin
      if (xm.valid && xm.used) begin
        n0 = '{valid: 1'b1, used: 1'b1, base: nb[BASE_W-1:0], len: xm.len};
        nn = 3'd1;
        nb_nx = nb + xm.len;
      end else if (xm.valid) begin
        free_nx = free_b + xm.len;
      end
      if (idx == IDX_W'(SEG_N - 1) && !cyc[IDX_W] && free_nx != '0) begin
        hole = '{valid: 1'b1, used: 1'b0, base: nb_nx[BASE_W-1:0], len: free_nx};
        if (nn == 3'd1) n1 = hole;
        else n0 = hole;
        nn = nn + 3'd1;
      end
    end else if (xm.valid) begin
      if (alloc_ok && idx == pick) begin
        if (split_need) begin
          n0 = '{valid: 1'b1, used: 1'b1, base: xm.base, len: size_r};
          n1 = '{valid: 1'b1, used: 1'b0, base: xm.base + size_r[BASE_W-1:0],
                 len: xm.len - size_r};
          nn = 3'd2;
        end else begin
          n0 = xm;
          n0.used = 1'b1;
          nn = 3'd1;
        end
      end else if (rel_ok && !xm.used && qn == 2'd1 && q0.valid && !q0.used) begin
        qm0.len = q0.len + xm.len;
      end else if (rel_ok && !xm.used && qn == 2'd2 && !q1.used) begin
        qm1.len = q1.len + xm.len;
      end else begin
        n0 = xm;
        nn = 3'd1;
      end
    end
    cn = {1'b0, qn} + nn;
    c[0] = '0;
    c[1] = '0;
    c[2] = '0;
    c[3] = '0;
    case (qn)
      2'd0: begin
        c[0] = n0;
        c[1] = n1;
      end
      2'd1: begin
        c[0] = qm0;
        c[1] = n0;
        c[2] = n1;
      end
      default: begin
        c[0] = qm0;
        c[1] = qm1;
        c[2] = n0;
        c[3] = n1;
      end
    endcase
    pop  = (cyc != '0) && (cn != 3'd0) && (!rel_ok || cn >= 3'd2 || cyc[IDX_W]);
    emit = pop ? c[0] : '0;
  end

  // cell chain control
  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.parity = cyc[0];
    tail_in    = '0;
    unique case (state)
      S_SCAN: begin
        ctl.op  = OP_SHIFT;
        tail_in = ents[0];
      end
      S_REWR: begin
        ctl.op  = OP_SHIFT;
        tail_in = emit;
      end
      S_SQZ: ctl.op = OP_SQZ;
      default: ;
    endcase
  end

  assign left_wall = '{valid: 1'b1, used: 1'b1, base: '0, len: '0};

  for (genvar g = 0; g < SEG_N; g++) begin : g_cell
    csa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .head     (1'(g == 0)),
      .odd      (1'(g % 2)),
      .ctl      (ctl),
      .left_in  ((g == 0) ? left_wall : ents[(g == 0) ? 0 : g - 1]),
      .right_in ((g == SEG_N - 1) ? tail_in : ents[(g == SEG_N - 1) ? g : g + 1]),
      .ent      (ents[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cyc      <= '0;
      m_tvalid <= 1'b0;
      qn       <= '0;
    end else begin
      if (state == S_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r   <= cmd_t'(s_tuser);
            mode_r  <= fit_t'(s_tdata[1:0]);
            size_r  <= s_tdata[22:2];
            start_r <= s_tdata[42:23];
            tot     <= '0;
            found   <= 1'b0;
            rfound  <= 1'b0;
            cyc     <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sx.valid) tot <= tot + CNT_W'(1);
          if (take) begin
            found     <= 1'b1;
            pick      <= idx;
            pick_len  <= sx.len;
            pick_base <= sx.base;
          end
          if (sx.valid && !rfound && sx.base == start_r) begin
            rfound <= 1'b1;
            ridx   <= idx;
            rused  <= sx.used;
          end
          if (idx == IDX_W'(SEG_N - 1)) begin
            cyc    <= '0;
            qn     <= '0;
            nb     <= '0;
            free_b <= '0;
            bytes  <= '0;
            ucnt   <= '0;
            hcnt   <= '0;
            state  <= S_REWR;
          end else begin
            cyc <= cyc + CNT_W'(1);
          end
        end
        S_REWR: begin
          if (pop) begin
            q0 <= c[1];
            q1 <= c[2];
            qn <= 2'(cn - 3'd1);
          end else begin
            q0 <= c[0];
            q1 <= c[1];
            qn <= 2'(cn);
          end
          nb     <= nb_nx;
          free_b <= free_nx;
          if (emit.valid) begin
            if (emit.used) begin
              bytes <= bytes + emit.len;
              ucnt  <= ucnt + CNT_W'(1);
            end else begin
              hcnt <= hcnt + CNT_W'(1);
            end
          end
          if (cyc[IDX_W]) begin
            cyc   <= '0;
            state <= S_SQZ;
          end else begin
            cyc <= cyc + CNT_W'(1);
          end
        end
        S_SQZ: begin
          cyc <= cyc + CNT_W'(1);
          if (idx == IDX_W'(SEG_N - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  status_t           st_out;
  logic [BASE_W-1:0] gr_out;

  always_comb begin
    case (cmd_r)
      CMD_ALLOC:   st_out = alloc_st;
      CMD_RELEASE: st_out = rel_ok ? ST_OK : ST_NOT_FOUND;
      default:     st_out = ST_OK;
    endcase
    gr_out = alloc_ok ? pick_base : '0;
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, hcnt, ucnt, bytes, gr_out, st_out};
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_REWR) |-> ((cn - 3'(pop)) <= 3'd2))
    else $error("rewrite queue overflow");

  a_queue_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQZ) |-> (qn == 2'd0))
    else $error("rewrite queue not drained");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> ((ucnt + hcnt) <= CNT_W'(SEG_N)))
    else $error("segment count exceeds table size");

endmodule
`default_nettype wire
